FILE: design/sop_pkg.sv
// Shared types and constants for the strip output placement block.
// Holds the configuration set, the stage payload structs and the field widths.
// Used by every module in the design folder.
package sop_pkg;

    localparam int COORD_BITS   = 16;
    localparam int POS_W        = 16;
    localparam int ROW_W        = 13;
    localparam int REL_W        = POS_W + 1;
    localparam int SCALE_W      = 12;
    localparam int ORIENT_W     = 4;
    localparam int SCALE_SHIFT  = 4;
    localparam int PROD_W       = REL_W + SCALE_W;
    localparam int SCL_W        = PROD_W - SCALE_SHIFT;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int IN_DATA_W    = 32;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(16);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CROP_ROW_START = 3'd0,
        REG_CROP_HEIGHT    = 3'd1,
        REG_CROP_WIDTH     = 3'd2,
        REG_SCALE_X16      = 3'd3,
        REG_SCALE_Y16      = 3'd4,
        REG_ORIENTATION    = 3'd5,
        REG_OFFSET_X       = 3'd6,
        REG_OFFSET_Y       = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [POS_W-1:0]    crop_row_start;
        logic [POS_W-1:0]    crop_height;
        logic [POS_W-1:0]    crop_width;
        logic [SCALE_W-1:0]  scale_x16;
        logic [SCALE_W-1:0]  scale_y16;
        logic [ORIENT_W-1:0] orientation;
        logic [POS_W-1:0]    offset_x;
        logic [POS_W-1:0]    offset_y;
    } t_cfg;

    typedef struct packed {
        logic             render;
        logic [ROW_W-1:0] src_start;
        logic [ROW_W-1:0] src_count;
        logic [POS_W-1:0] a_rel;
        logic [REL_W-1:0] b_rel;
    } t_clip;

    typedef struct packed {
        logic             render;
        logic [ROW_W-1:0] src_start;
        logic [ROW_W-1:0] src_count;
        logic [SCL_W-1:0] a_sc;
        logic [SCL_W-1:0] b_sc;
        logic [SCL_W-1:0] sw;
        logic [SCL_W-1:0] sh;
    } t_scal;

    typedef struct packed {
        logic             render;
        logic [ROW_W-1:0] src_start;
        logic [ROW_W-1:0] src_count;
        logic [SCL_W-1:0] x;
        logic [SCL_W-1:0] y;
        logic [SCL_W-1:0] w;
        logic [SCL_W-1:0] h;
    } t_plc;

endpackage

FILE: design/sop_clip.sv
// First pipeline stage: clips the strip to the crop band.
// Depends on sop_pkg for the configuration and stage payload types.
module sop_clip (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sop_pkg::t_cfg              i_cfg,
    input  logic                       i_vld,
    output logic                       o_rdy,
    input  logic [sop_pkg::POS_W-1:0]  i_row_offset,
    input  logic [sop_pkg::ROW_W-1:0]  i_rows,
    output logic                       o_vld,
    input  logic                       i_rdy,
    output sop_pkg::t_clip             o_data
);

    logic                         r_vld;
    sop_pkg::t_clip               r_data;
    sop_pkg::t_clip               n_data;
    logic [sop_pkg::POS_W-1:0]    a_abs;
    logic [sop_pkg::REL_W-1:0]    s_end;
    logic [sop_pkg::REL_W-1:0]    c_end;
    logic [sop_pkg::REL_W-1:0]    b_abs;
    logic [sop_pkg::REL_W-1:0]    a_ext;
    logic [sop_pkg::POS_W-1:0]    start_diff;
    logic [sop_pkg::REL_W-1:0]    count_diff;

    always_comb begin
        a_abs = (i_cfg.crop_row_start > i_row_offset) ? i_cfg.crop_row_start : i_row_offset;
        a_ext = {1'b0, a_abs};
        s_end = {1'b0, i_row_offset} + sop_pkg::REL_W'(i_rows);
        c_end = {1'b0, i_cfg.crop_row_start} + {1'b0, i_cfg.crop_height};
        b_abs = (s_end < c_end) ? s_end : c_end;
        start_diff = a_abs - i_row_offset;
        count_diff = b_abs - a_ext;
        n_data.render    = b_abs > a_ext;
        n_data.src_start = start_diff[sop_pkg::ROW_W-1:0];
        n_data.src_count = count_diff[sop_pkg::ROW_W-1:0];
        n_data.a_rel     = a_abs - i_cfg.crop_row_start;
        n_data.b_rel     = b_abs - {1'b0, i_cfg.crop_row_start};
    end

    assign o_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
        if (o_rdy && i_vld) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

FILE: design/sop_scale.sv
// Second pipeline stage: scales band rows and crop sizes by the factors in sixteenths.
// Depends on sop_pkg; holds the four narrow multipliers of the block.
module sop_scale (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sop_pkg::t_cfg  i_cfg,
    input  logic           i_vld,
    output logic           o_rdy,
    input  sop_pkg::t_clip i_data,
    output logic           o_vld,
    input  logic           i_rdy,
    output sop_pkg::t_scal o_data
);

    logic                          r_vld;
    sop_pkg::t_scal                r_data;
    sop_pkg::t_scal                n_data;
    logic [sop_pkg::PROD_W-1:0]    prod_a;
    logic [sop_pkg::PROD_W-1:0]    prod_b;
    logic [sop_pkg::PROD_W-1:0]    prod_w;
    logic [sop_pkg::PROD_W-1:0]    prod_h;

    always_comb begin
        prod_a = sop_pkg::PROD_W'(i_data.a_rel) * sop_pkg::PROD_W'(i_cfg.scale_y16);
        prod_b = sop_pkg::PROD_W'(i_data.b_rel) * sop_pkg::PROD_W'(i_cfg.scale_y16);
        prod_w = sop_pkg::PROD_W'(i_cfg.crop_width) * sop_pkg::PROD_W'(i_cfg.scale_x16);
        prod_h = sop_pkg::PROD_W'(i_cfg.crop_height) * sop_pkg::PROD_W'(i_cfg.scale_y16);
        n_data.render    = i_data.render;
        n_data.src_start = i_data.src_start;
        n_data.src_count = i_data.src_count;
        n_data.a_sc      = prod_a[sop_pkg::PROD_W-1:sop_pkg::SCALE_SHIFT];
        n_data.b_sc      = prod_b[sop_pkg::PROD_W-1:sop_pkg::SCALE_SHIFT];
        n_data.sw        = prod_w[sop_pkg::PROD_W-1:sop_pkg::SCALE_SHIFT];
        n_data.sh        = prod_h[sop_pkg::PROD_W-1:sop_pkg::SCALE_SHIFT];
    end

    assign o_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
        if (o_rdy && i_vld) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

FILE: design/sop_place.sv
// Third pipeline stage: places the scaled band under rotation and mirroring.
// Depends on sop_pkg for the stage payload types.
module sop_place (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sop_pkg::t_cfg  i_cfg,
    input  logic           i_vld,
    output logic           o_rdy,
    input  sop_pkg::t_scal i_data,
    output logic           o_vld,
    input  logic           i_rdy,
    output sop_pkg::t_plc  o_data
);

    logic                         r_vld;
    sop_pkg::t_plc                r_data;
    sop_pkg::t_plc                n_data;
    logic                         odd_rot;
    logic                         mirror;
    logic                         far_side;
    logic [sop_pkg::SCL_W-1:0]    band;
    logic [sop_pkg::SCL_W-1:0]    pos;

    // The band lies along y for rotations 0 and 180 and along x for 90 and 270.
    // Its position is measured from the near edge (A) or the far edge (scaled height minus B).
    always_comb begin
        odd_rot  = i_cfg.orientation[0];
        mirror   = odd_rot ? i_cfg.orientation[2] : i_cfg.orientation[3];
        far_side = i_cfg.orientation[1] ^ mirror;
        band     = i_data.b_sc - i_data.a_sc;
        pos      = far_side ? (i_data.sh - i_data.b_sc) : i_data.a_sc;
        n_data.render    = i_data.render;
        n_data.src_start = i_data.src_start;
        n_data.src_count = i_data.src_count;
        n_data.x         = odd_rot ? pos : '0;
        n_data.y         = odd_rot ? '0 : pos;
        n_data.w         = odd_rot ? band : i_data.sw;
        n_data.h         = odd_rot ? i_data.sw : band;
    end

    assign o_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
        if (o_rdy && i_vld) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

FILE: design/sop_sat.sv
// Last pipeline stage: adds the output offset and saturates the coordinates.
// Depends on sop_pkg; its register is the output register of the block.
module sop_sat #(
    parameter int COORD_BITS = sop_pkg::COORD_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sop_pkg::t_cfg              i_cfg,
    input  logic                       i_vld,
    output logic                       o_rdy,
    input  sop_pkg::t_plc              i_data,
    output logic                       o_vld,
    input  logic                       i_rdy,
    output logic                       o_render,
    output logic [sop_pkg::ROW_W-1:0]  o_src_start,
    output logic [sop_pkg::ROW_W-1:0]  o_src_count,
    output logic [COORD_BITS-1:0]      o_x,
    output logic [COORD_BITS-1:0]      o_y,
    output logic [COORD_BITS-1:0]      o_w,
    output logic [COORD_BITS-1:0]      o_h
);

    localparam int SUM_W = sop_pkg::SCL_W + 1;
    localparam int EXT_W = (COORD_BITS > SUM_W) ? COORD_BITS : SUM_W;

    function automatic logic [COORD_BITS-1:0] sat(input logic [SUM_W-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        if ((ext >> COORD_BITS) != '0) begin
            sat = '1;
        end else begin
            sat = ext[COORD_BITS-1:0];
        end
    endfunction

    logic                         r_vld;
    logic                         r_render;
    logic [sop_pkg::ROW_W-1:0]    r_src_start;
    logic [sop_pkg::ROW_W-1:0]    r_src_count;
    logic [COORD_BITS-1:0]        r_x;
    logic [COORD_BITS-1:0]        r_y;
    logic [COORD_BITS-1:0]        r_w;
    logic [COORD_BITS-1:0]        r_h;
    logic [SUM_W-1:0]             sum_x;
    logic [SUM_W-1:0]             sum_y;
    logic                         keep;

    always_comb begin
        keep  = i_data.render;
        sum_x = SUM_W'(i_cfg.offset_x) + SUM_W'(i_data.x);
        sum_y = SUM_W'(i_cfg.offset_y) + SUM_W'(i_data.y);
    end

    assign o_rdy = !r_vld || i_rdy;

    // A skipped strip gives an all-zero result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
        if (o_rdy && i_vld) begin
            r_render    <= keep;
            r_src_start <= keep ? i_data.src_start : '0;
            r_src_count <= keep ? i_data.src_count : '0;
            r_x         <= keep ? sat(sum_x) : '0;
            r_y         <= keep ? sat(sum_y) : '0;
            r_w         <= keep ? sat(SUM_W'(i_data.w)) : '0;
            r_h         <= keep ? sat(SUM_W'(i_data.h)) : '0;
        end
    end

    assign o_vld       = r_vld;
    assign o_render    = r_render;
    assign o_src_start = r_src_start;
    assign o_src_count = r_src_count;
    assign o_x         = r_x;
    assign o_y         = r_y;
    assign o_w         = r_w;
    assign o_h         = r_h;

endmodule

FILE: design/strip_output_placement.sv
// Top level of the strip output placement block: configuration registers and four stages.
// Depends on sop_pkg, sop_clip, sop_scale, sop_place and sop_sat.
//
//   Channel   Direction  Handshake                   Payload
//   s_axis    in         i_s_axis_tvalid/tready      strip_row_offset, strip_rows
//   m_axis    out        o_m_axis_tvalid/tready      render in tuser, rows and block in tdata
//   cfg       in         i_cfg_valid/o_cfg_ready     register index and write data
//
// One item enters per cycle while no stall has backed up to the input; each item is
// registered in turn by the four register stages: clip, multiply, place, saturate.
// A stalled output holds its stage; earlier stages keep filling their empty slots.
// Synchronous active-low reset empties the pipeline and loads the register defaults.
module strip_output_placement #(
    parameter int COORD_BITS = sop_pkg::COORD_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [sop_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [sop_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // strip_row_offset [15:0], strip_rows [28:16], zero fill above
    input  logic [sop_pkg::IN_DATA_W-1:0]        i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // src_row_start, src_row_count, out_x, out_y, out_w, out_h, zero fill above
    output logic [((2*sop_pkg::ROW_W+4*COORD_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    // render
    output logic [0:0]                           o_m_axis_tuser
);

    localparam int OUT_USED_W = 2 * sop_pkg::ROW_W + 4 * COORD_BITS;
    localparam int OUT_W      = ((OUT_USED_W + 7) / 8) * 8;

    sop_pkg::t_cfg               r_cfg;
    sop_pkg::t_clip              clip_data;
    sop_pkg::t_scal              scal_data;
    sop_pkg::t_plc               plc_data;
    logic                        clip_vld;
    logic                        clip_rdy;
    logic                        scal_vld;
    logic                        scal_rdy;
    logic                        plc_vld;
    logic                        plc_rdy;
    logic                        out_render;
    logic [sop_pkg::ROW_W-1:0]   out_start;
    logic [sop_pkg::ROW_W-1:0]   out_count;
    logic [COORD_BITS-1:0]       out_x;
    logic [COORD_BITS-1:0]       out_y;
    logic [COORD_BITS-1:0]       out_w;
    logic [COORD_BITS-1:0]       out_h;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crop_row_start <= '0;
            r_cfg.crop_height    <= '0;
            r_cfg.crop_width     <= '0;
            r_cfg.scale_x16      <= sop_pkg::SCALE_RESET;
            r_cfg.scale_y16      <= sop_pkg::SCALE_RESET;
            r_cfg.orientation    <= '0;
            r_cfg.offset_x       <= '0;
            r_cfg.offset_y       <= '0;
        end else if (i_cfg_valid) begin
            unique case (sop_pkg::t_reg_idx'(i_cfg_index))
                sop_pkg::REG_CROP_ROW_START: r_cfg.crop_row_start <= i_cfg_data;
                sop_pkg::REG_CROP_HEIGHT:    r_cfg.crop_height    <= i_cfg_data;
                sop_pkg::REG_CROP_WIDTH:     r_cfg.crop_width     <= i_cfg_data;
                sop_pkg::REG_SCALE_X16: begin
                    r_cfg.scale_x16 <= i_cfg_data[sop_pkg::SCALE_W-1:0];
                end
                sop_pkg::REG_SCALE_Y16: begin
                    r_cfg.scale_y16 <= i_cfg_data[sop_pkg::SCALE_W-1:0];
                end
                sop_pkg::REG_ORIENTATION: begin
                    r_cfg.orientation <= i_cfg_data[sop_pkg::ORIENT_W-1:0];
                end
                sop_pkg::REG_OFFSET_X:       r_cfg.offset_x       <= i_cfg_data;
                sop_pkg::REG_OFFSET_Y:       r_cfg.offset_y       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sop_clip u_clip (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_vld        (i_s_axis_tvalid),
        .o_rdy        (o_s_axis_tready),
        .i_row_offset (i_s_axis_tdata[sop_pkg::POS_W-1:0]),
        .i_rows       (i_s_axis_tdata[sop_pkg::POS_W+sop_pkg::ROW_W-1:sop_pkg::POS_W]),
        .o_vld        (clip_vld),
        .i_rdy        (clip_rdy),
        .o_data       (clip_data)
    );

    sop_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (clip_vld),
        .o_rdy   (clip_rdy),
        .i_data  (clip_data),
        .o_vld   (scal_vld),
        .i_rdy   (scal_rdy),
        .o_data  (scal_data)
    );

    sop_place u_place (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (scal_vld),
        .o_rdy   (scal_rdy),
        .i_data  (scal_data),
        .o_vld   (plc_vld),
        .i_rdy   (plc_rdy),
        .o_data  (plc_data)
    );

    sop_sat #(
        .COORD_BITS (COORD_BITS)
    ) u_sat (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_vld       (plc_vld),
        .o_rdy       (plc_rdy),
        .i_data      (plc_data),
        .o_vld       (o_m_axis_tvalid),
        .i_rdy       (i_m_axis_tready),
        .o_render    (out_render),
        .o_src_start (out_start),
        .o_src_count (out_count),
        .o_x         (out_x),
        .o_y         (out_y),
        .o_w         (out_w),
        .o_h         (out_h)
    );

    assign o_m_axis_tuser = out_render;
    assign o_m_axis_tdata = OUT_W'({out_h, out_w, out_y, out_x, out_count, out_start});

    // A skipped strip carries no row range and no block.
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("skipped item carries nonzero data");

    // A kept strip always uses at least one row.
    a_kept_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (out_count != '0))
        else $error("kept item has an empty row range");

    // Input back-pressure only appears when every stage holds an item.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (clip_vld && scal_vld && plc_vld && o_m_axis_tvalid))
        else $error("input stalled with an empty stage");

    // An item that leaves the clip stage is registered in the scale stage.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (clip_vld && clip_rdy) |=> scal_vld)
        else $error("clip stage item lost");

endmodule
